>>> sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue: operation codes,
// status codes, field widths and the control word handed to a row of cells.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int OP_W     = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int ELEM_W   = 5;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef struct packed {
        logic shr;
        logic shl;
        logic load;
    } t_row_ctrl;

endpackage

>>> sv/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the queue row: holds one element and each cycle either
// keeps it, takes its left or right neighbor, or loads the pushed value.
// ----------------------------------------------------------------------------
module deq_cell (
    input  logic               i_clk,
    input  deq_pkg::t_row_ctrl i_ctrl,
    input  deq_pkg::t_data     i_left,
    input  deq_pkg::t_data     i_right,
    input  deq_pkg::t_data     i_value,
    output deq_pkg::t_data     o_data
);
    import deq_pkg::*;

    t_data r_data;
    t_data n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.shr) begin
            n_data = i_left;
        end else if (i_ctrl.shl) begin
            n_data = i_right;
        end else if (i_ctrl.load) begin
            n_data = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

>>> sv/deq_row.sv
// ----------------------------------------------------------------------------
// deq_row
// A row of cells with its head at cell 0: shift right with insert at the
// head, shift left toward the head, or load the cell at the current count.
// ----------------------------------------------------------------------------
module deq_row #(
    parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  deq_pkg::t_row_ctrl                 i_ctrl,
    input  logic [$clog2(CAPACITY+1)-1:0]      i_count,
    input  deq_pkg::t_data                     i_value,
    output deq_pkg::t_data                     o_head
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_data cell_q [CAPACITY];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_row_ctrl cell_ctrl;
            t_data     left_d;
            t_data     right_d;

            assign cell_ctrl.shr  = i_ctrl.shr;
            assign cell_ctrl.shl  = i_ctrl.shl;
            assign cell_ctrl.load = i_ctrl.load && (i_count == CNT_W'(gi));

            if (gi == 0) begin : g_first
                assign left_d = i_value;
            end else begin : g_mid_l
                assign left_d = cell_q[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign right_d = '0;
            end else begin : g_mid_r
                assign right_d = cell_q[gi+1];
            end

            deq_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (cell_ctrl),
                .i_left  (left_d),
                .i_right (right_d),
                .i_value (i_value),
                .o_data  (cell_q[gi])
            );
        end
    endgenerate

    assign o_head = cell_q[0];

endmodule

>>> sv/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values built from two mirrored rows of
// cells: one row keeps the front at its head, the other keeps the back.
//
//   channel   direction  handshake          fields
//   input     in         i_valid / o_stall  i_op, i_value
//   output    out        o_valid / i_stall  o_status, o_elements,
//                                           o_front_value, o_back_value,
//                                           o_is_empty
//
// One operation per cycle while the output is not stalled; the result appears the cycle after the beat.
// A push updates both rows and a pop shifts only its own row; the count updates in the cycle of the beat.
// Reset clears the count and the output valid; cell contents stay unknown.
// A stalled result holds, and the input stalls only while it waits.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [deq_pkg::OP_W-1:0]          i_op,
    input  logic signed [deq_pkg::DATA_W-1:0] i_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [deq_pkg::STATUS_W-1:0]      o_status,
    output logic [deq_pkg::ELEM_W-1:0]        o_elements,
    output logic signed [deq_pkg::DATA_W-1:0] o_front_value,
    output logic signed [deq_pkg::DATA_W-1:0] o_back_value,
    output logic                              o_is_empty
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                r_vld;
    logic                n_vld;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;

    t_row_ctrl f_ctrl;
    t_row_ctrl b_ctrl;
    t_data     f_head;
    t_data     b_head;
    logic      accept;
    logic      full;
    logic      empty;

    assign o_stall = r_vld && i_stall;
    assign accept  = i_valid && !o_stall;
    assign full    = (r_count == CNT_W'(CAPACITY));
    assign empty   = (r_count == '0);

    always_comb begin
        f_ctrl   = '0;
        b_ctrl   = '0;
        n_count  = r_count;
        n_status = r_status;
        n_vld    = r_vld && i_stall;
        if (accept) begin
            n_vld    = 1'b1;
            n_status = ST_DONE;
            case (i_op)
                OP_PUSH_FRONT: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        f_ctrl.shr  = 1'b1;
                        b_ctrl.load = 1'b1;
                        n_count     = r_count + 1'b1;
                    end
                end
                OP_PUSH_BACK: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        b_ctrl.shr  = 1'b1;
                        f_ctrl.load = 1'b1;
                        n_count     = r_count + 1'b1;
                    end
                end
                OP_POP_FRONT: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        f_ctrl.shl = 1'b1;
                        n_count    = r_count - 1'b1;
                    end
                end
                OP_POP_BACK: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        b_ctrl.shl = 1'b1;
                        n_count    = r_count - 1'b1;
                    end
                end
                default: begin
                    n_status = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_count  <= '0;
            r_status <= ST_DONE;
        end else begin
            r_vld    <= n_vld;
            r_count  <= n_count;
            r_status <= n_status;
        end
    end

    deq_row #(.CAPACITY(CAPACITY)) u_front_row (
        .i_clk   (i_clk),
        .i_ctrl  (f_ctrl),
        .i_count (r_count),
        .i_value (i_value),
        .o_head  (f_head)
    );

    deq_row #(.CAPACITY(CAPACITY)) u_back_row (
        .i_clk   (i_clk),
        .i_ctrl  (b_ctrl),
        .i_count (r_count),
        .i_value (i_value),
        .o_head  (b_head)
    );

    assign o_valid       = r_vld;
    assign o_status      = r_status;
    assign o_elements    = ELEM_W'(r_count);
    assign o_front_value = empty ? '0 : f_head;
    assign o_back_value  = empty ? '0 : b_head;
    assign o_is_empty    = empty;

endmodule
